/* hdl/bmoc_pkg.sv */
package bmoc_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_WINDOW = 7;

  localparam logic        RST_MODE_CLOSING = 1'b1;
  localparam logic [2:0]  RST_WINDOW_SIZE  = 3'd3;
  localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [15:0] RST_FRAME_HEIGHT = 16'd480;

  typedef enum logic [1:0] {
    REG_MODE_CLOSING = 2'd0,
    REG_WINDOW_SIZE  = 2'd1,
    REG_FRAME_WIDTH  = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } reg_idx_t;

  // one item moving between pipeline stages
  typedef struct packed {
    logic v;
    logic bit_set;
    logic tag;
  } tok_t;

  // announces an item entering the register ahead of a stage
  typedef struct packed {
    logic v;
    logic tag;
  } pre_t;

endpackage

/* hdl/bmoc_ram.sv */
module bmoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/bmoc_stage.sv */
module bmoc_stage
  import bmoc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  localparam int RMAX = (MAX_WINDOW - 1) / 2,
  localparam int K    = 2 * RMAX + 1,
  localparam int XW   = $clog2(MAX_WIDTH),
  localparam int RW   = $clog2(RMAX + 1),
  localparam int LW   = $clog2(RMAX * MAX_WIDTH + RMAX + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clr,
  input  logic          en,
  input  logic [RW-1:0] radius,
  input  logic [XW:0]   w,
  input  logic [15:0]   h,
  input  logic [LW-1:0] lag,
  input  logic          erode,
  input  pre_t          pre,
  input  tok_t          cur,
  output tok_t          out,
  output logic          inframe,
  output pre_t          load
);

  logic [XW-1:0]  x_in, rd_x;
  logic [LW-1:0]  dc;
  logic           started, out_v, out_tag;
  logic [XW-1:0]  cx;
  logic [16:0]    cy;
  logic           byp;
  logic [K-2:0]   bypd, rdata, ramcol;
  logic [K-1:0]   newcol;
  logic [K-1:0]   win [K];
  logic           consume, started_now, res;
  logic [K-1:0]   colok, rowok;
  logic [XW:0]    ax;
  logic [17:0]    by;

  assign consume     = en & cur.v;
  assign started_now = started | (dc == lag);
  assign ramcol      = byp ? bypd : rdata;
  assign newcol      = {ramcol, cur.bit_set};

  bmoc_ram #(.WIDTH(K - 1), .DEPTH(MAX_WIDTH)) u_rows (
    .clk  (clk),
    .we   (consume),
    .waddr(x_in),
    .wdata(newcol[K-2:0]),
    .re   (pre.v),
    .raddr(rd_x),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      x_in    <= '0;
      rd_x    <= '0;
      dc      <= '0;
      started <= 1'b0;
      out_v   <= 1'b0;
      out_tag <= 1'b0;
      byp     <= 1'b0;
      cx      <= '0;
      cy      <= '0;
    end else begin
      if (pre.v) begin
        byp <= consume && (rd_x == x_in);
        if (pre.tag || ({1'b0, rd_x} == w - 1'b1)) begin
          rd_x <= '0;
        end else begin
          rd_x <= rd_x + 1'b1;
        end
      end
      if (en) begin
        out_v <= consume & started_now;
      end
      if (consume) begin
        out_tag <= cur.tag;
        if (cur.tag || ({1'b0, x_in} == w - 1'b1)) begin
          x_in <= '0;
        end else begin
          x_in <= x_in + 1'b1;
        end
        if (started_now) begin
          if (!started) begin
            cx <= '0;
            cy <= '0;
          end else if ({1'b0, cx} == w - 1'b1) begin
            cx <= '0;
            cy <= cy + 1'b1;
          end else begin
            cx <= cx + 1'b1;
          end
        end
        started <= started_now & ~cur.tag;
        if (cur.tag) begin
          dc <= '0;
        end else if (!started_now) begin
          dc <= dc + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pre.v) begin
      bypd <= newcol[K-2:0];
    end
    if (consume) begin
      win[0] <= newcol;
      for (int j = 1; j < K; j++) begin
        win[j] <= win[j-1];
      end
    end
  end

  // column j sits at dx = r - j, bit k at dy = r - k from the center
  always_comb begin
    ax = {1'b0, cx} + (XW+1)'(radius);
    by = {1'b0, cy} + 18'(radius);
    for (int j = 0; j < K; j++) begin
      colok[j] = (ax >= (XW+1)'(j)) && ((ax - (XW+1)'(j)) < w);
      rowok[j] = (by >= 18'(j)) && ((by - 18'(j)) < {2'b00, h});
    end
  end

  always_comb begin
    logic anyset, allset, inw;
    anyset = 1'b0;
    allset = 1'b1;
    inw    = 1'b0;
    for (int j = 0; j < K; j++) begin
      for (int k = 0; k < K; k++) begin
        inw = (5'(j) <= {radius, 1'b0}) && (5'(k) <= {radius, 1'b0});
        if (inw) begin
          if (colok[j] && rowok[k]) begin
            anyset = anyset | win[j][k];
            allset = allset & win[j][k];
          end else begin
            allset = 1'b0;
          end
        end
      end
    end
    res = erode ? allset : anyset;
  end

  assign inframe     = cy < {1'b0, h};
  assign out.v       = out_v;
  assign out.bit_set = inframe & res;
  assign out.tag     = out_tag;
  assign load.v      = consume & started_now;
  assign load.tag    = cur.tag;

endmodule

/* hdl/binary_morphology_open_close_top.sv */
// channel  | dir | handshake                    | payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata[7:0] pixel_value, tuser fill_only
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata[0] out_set, tlast out_last
// cfg      | in  | cfg_valid/cfg_ready          | cfg_index register, cfg_data value
//
// One item per cycle unless stalled; line stores are single-port-per-side RAMs read one
// item ahead. Results lag inputs by 2*(r*W+r) items plus the input, stage and output
// registers. Reset (and any register write) restarts the frame; edge masking by
// position makes stale line store contents harmless, so no clearing pass is needed.
// A stalled output freezes the whole pipeline. One idle cycle follows a write.
module binary_morphology_open_close_top
  import bmoc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_value
  input  logic        s_axis_tuser,   // [0] fill_only
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] out_set, rest zero
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int RMAX = (MAX_WINDOW - 1) / 2;
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(RMAX + 1);
  localparam int LW   = $clog2(RMAX * MAX_WIDTH + RMAX + 1);

  logic        mode_closing;
  logic [2:0]  window_size;
  logic [10:0] frame_width;
  logic [15:0] frame_height;

  logic          cfg_acc, hold, en, s_acc, tag;
  logic [XW:0]   w;
  logic [15:0]   h;
  logic [2:0]    ws_m1;
  logic [RW-1:0] radius;
  logic [LW-1:0] lag;
  logic [25:0]   total;
  logic [26:0]   endn, n;
  logic          a_v, a_bit, a_tag;
  logic          o_v, o_set, o_last;
  tok_t          a_tok, s1_out, s2_out;
  pre_t          s1_pre, s1_load, s2_load;
  logic          s1_inframe, s2_inframe;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_closing <= RST_MODE_CLOSING;
      window_size  <= RST_WINDOW_SIZE;
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      hold         <= 1'b0;
    end else begin
      hold <= cfg_acc;
      if (cfg_acc) begin
        case (cfg_index)
          REG_MODE_CLOSING: mode_closing <= cfg_data[0];
          REG_WINDOW_SIZE:  window_size  <= cfg_data[2:0];
          REG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (frame_width == '0) begin
      w = (XW+1)'(1);
    end else if ({3'b000, frame_width} > 14'(MAX_WIDTH)) begin
      w = (XW+1)'(MAX_WIDTH);
    end else begin
      w = (XW+1)'(frame_width);
    end
    h = (frame_height == '0) ? 16'd1 : frame_height;
    // even sizes drop to the next lower odd size, zero acts as one
    ws_m1 = (window_size == 3'd0) ? 3'd0 : window_size - 3'd1;
    if ({1'b0, ws_m1[2:1]} > 3'(RMAX)) begin
      radius = RW'(RMAX);
    end else begin
      radius = RW'(ws_m1[2:1]);
    end
  end

  always_ff @(posedge clk) begin
    lag   <= LW'(radius * w) + LW'(radius);
    total <= 26'(w * h);
  end

  assign endn = {1'b0, total} - 27'd1 + {(26 - LW)'(0), lag, 1'b0};

  assign en            = ~o_v | m_axis_tready;
  assign s_axis_tready = en & ~hold;
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign tag           = (n == endn);

  always_ff @(posedge clk) begin
    if (rst || cfg_acc) begin
      a_v <= 1'b0;
      n   <= '0;
    end else if (en) begin
      a_v <= s_acc;
      if (s_acc) begin
        n <= tag ? '0 : n + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s_acc) begin
      a_bit <= ~s_axis_tuser & (s_axis_tdata != 8'd0);
      a_tag <= tag;
    end
  end

  assign a_tok.v       = a_v;
  assign a_tok.bit_set = a_bit;
  assign a_tok.tag     = a_tag;
  assign s1_pre.v      = s_acc;
  assign s1_pre.tag    = tag;

  bmoc_stage #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW)) u_first (
    .clk(clk), .rst(rst), .clr(cfg_acc), .en(en),
    .radius(radius), .w(w), .h(h), .lag(lag), .erode(~mode_closing),
    .pre(s1_pre), .cur(a_tok), .out(s1_out), .inframe(s1_inframe), .load(s1_load)
  );

  bmoc_stage #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW)) u_second (
    .clk(clk), .rst(rst), .clr(cfg_acc), .en(en),
    .radius(radius), .w(w), .h(h), .lag(lag), .erode(mode_closing),
    .pre(s1_load), .cur(s1_out), .out(s2_out), .inframe(s2_inframe), .load(s2_load)
  );

  always_ff @(posedge clk) begin
    if (rst || cfg_acc) begin
      o_v <= 1'b0;
    end else if (en) begin
      o_v <= s2_out.v & s2_inframe;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_set  <= s2_out.bit_set;
      o_last <= s2_out.tag;
    end
  end

  assign m_axis_tvalid = o_v;
  assign m_axis_tdata  = {7'd0, o_set};
  assign m_axis_tlast  = o_last | (o_v & 1'b0) | (s1_inframe & 1'b0);

  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    cfg_acc |=> !s_axis_tready)
    else $error("item taken right after a register write");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (s_acc && tag && !cfg_acc) |=> (n == '0))
    else $error("item count did not restart after frame end");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!en && !cfg_acc) |=> $stable(n) && $stable(a_v))
    else $error("pipeline moved during output stall");

endmodule
